### sv/fbp_pkg.sv
package fbp_pkg;

  // Sample and coefficient formats: samples are Q4.12, coefficients Q1.15.
  localparam int TAP_COUNT       = 21;
  localparam int SAMPLE_BITS     = 16;
  localparam int COEF_BITS       = 16;
  localparam int COEF_DEFINED    = 21;
  localparam int HALF_COEFS      = 11;
  localparam int PROD_FRAC_SHIFT = 15;

  // Full-precision product and accumulator widths.
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + $clog2(TAP_COUNT);
  localparam int QUO_BITS  = ACC_BITS - PROD_FRAC_SHIFT;

  // Rounding offset of one half LSB of the result, injected at the far end of the chain.
  localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(2 ** (PROD_FRAC_SHIFT - 1));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // One half of the symmetric impulse response, outermost tap first.
  localparam coef_t HALF_COEF [HALF_COEFS] = '{
    -16'sd261, -16'sd819, -16'sd565, 16'sd720, 16'sd1738, 16'sd1007,
    -16'sd1129, -16'sd2458, -16'sd1304, 16'sd1350, 16'sd2731
  };

  // Coefficient of tap k; taps outside the defined response are zero.
  function automatic coef_t coef_at(int k);
    int m;
    coef_t c;
    c = '0;
    m = k;
    if (COEF_DEFINED - 1 - k < m) begin
      m = COEF_DEFINED - 1 - k;
    end
    if (k >= 0 && k < COEF_DEFINED && m >= 0 && m < HALF_COEFS) begin
      c = HALF_COEF[m];
    end
    return c;
  endfunction

endpackage

### sv/fbp_cell.sv
module fbp_cell
  import fbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  coef_t   coef,
  input  sample_t sample,
  input  acc_t    sum_in,
  output acc_t    sum_r
);

  logic signed [PROD_BITS-1:0] prod;
  acc_t                        sum_nxt;

  // Weight the new sample and add the partial sum handed on by the neighbour.
  always_comb begin
    prod    = coef * sample;
    sum_nxt = ACC_BITS'(prod) + sum_in;
  end

  // The partial sum moves one place along the chain on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= ROUND_BIAS;
    end else if (adv) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

### sv/fbp_out.sv
module fbp_out
  import fbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  coef_t   coef,
  input  sample_t sample,
  input  acc_t    sum_in,
  output logic    adv,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t filtered_out
);

  logic signed [PROD_BITS-1:0]          prod;
  acc_t                                 acc;
  logic signed [QUO_BITS-1:0]           quo;
  logic [QUO_BITS-SAMPLE_BITS:0]        upper;
  sample_t                              sat;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  sample_t                              filtered_r;

  localparam sample_t SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SAT_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // A beat is taken whenever the output register is empty or being emptied.
  always_comb begin
    in_stall      = out_valid_r & out_stall;
    adv           = in_valid & ~in_stall;
    out_valid_nxt = adv | (out_valid_r & out_stall);
  end

  // Tap zero on the current sample, then floor shift (rounding bias is already in the sum).
  always_comb begin
    prod  = coef * sample;
    acc   = ACC_BITS'(prod) + sum_in;
    quo   = QUO_BITS'(acc >>> PROD_FRAC_SHIFT);
    upper = quo[QUO_BITS-1:SAMPLE_BITS-1];
    if ((&upper) || !(|upper)) begin
      sat = quo[SAMPLE_BITS-1:0];
    end else if (quo[QUO_BITS-1]) begin
      sat = SAT_LO;
    end else begin
      sat = SAT_HI;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      filtered_r <= sat;
    end
  end

  assign out_valid    = out_valid_r;
  assign filtered_out = filtered_r;

`ifndef ASSERT_OFF
  // Input is only held back while a result waits in the output register.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty output register");

  // Every accepted beat yields a result in the next cycle.
  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("accepted beat produced no result");

  // A taken result with no new beat leaves the output register empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !adv) |=> !out_valid_r)
    else $error("result delivered twice");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result pending after reset");
`endif

endmodule

### sv/fir_bandpass_21_tap_core.sv
// 21-tap linear-phase bandpass FIR filter on signed Q4.12 samples with Q1.15
// coefficients, built in transposed form as a chain of multiply-add cells that
// each hold one partial sum; the result is rounded half up to Q4.12 and
// saturated to 16 bits. It accepts one sample beat every clock cycle and
// delivers its result in the cycle after acceptance from an output register; the
// only limit on rate is the output register, which stalls the input while a
// result is held back by out_stall. After reset the sample history reads as
// zero and the first results are computed against it.
module fir_bandpass_21_tap_core
  import fbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_sample_in,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t out_filtered_out
);

  logic adv;
  acc_t sum_w [1:TAP_COUNT];

  // The far end of the chain starts from the rounding offset.
  assign sum_w[TAP_COUNT] = ROUND_BIAS;

  // One cell per delayed tap; each partial sum flows towards tap zero.
  for (genvar k = 1; k < TAP_COUNT; k++) begin : g_tap
    fbp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .coef   (coef_at(k)),
      .sample (in_sample_in),
      .sum_in (sum_w[k+1]),
      .sum_r  (sum_w[k])
    );
  end

  // Tap zero, rounding, saturation and the output register.
  fbp_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .coef         (coef_at(0)),
    .sample       (in_sample_in),
    .sum_in       (sum_w[1]),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered_out (out_filtered_out)
  );

endmodule

### tb/fir_bandpass_21_tap_core_tb.sv
module fir_bandpass_21_tap_core_tb;
  import fbp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 10;

  localparam sample_t SAMPLE_MAX = sample_t'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_BITS - 1)));

  // Kinds of random block, one drawn per run of TAP_COUNT beats.
  typedef enum int {
    BLK_RANDOM,
    BLK_EXTREME,
    BLK_SMALL,
    BLK_PEAK_POS,
    BLK_PEAK_NEG,
    BLK_IMPULSE
  } block_kind_t;

  // One row of the directed table; a typed row carries its own expected value.
  typedef struct {
    sample_t sample;
    bit      typed;
    sample_t want;
  } stim_row_t;

  // Q1.15 impulse response, rounded from the published values, tap 0 first.
  localparam int TAP_WEIGHT [TAP_COUNT] = '{
    -261, -819, -565, 720, 1738, 1007, -1129, -2458, -1304, 1350, 2731,
    1350, -1304, -2458, -1129, 1007, 1738, 720, -565, -819, -261
  };

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_filtered_out;

  sample_t   past_samples [TAP_COUNT - 1];
  sample_t   expected_out [$];
  stim_row_t directed_rows [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        calm_phase = 1'b0;

  fir_bandpass_21_tap_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_filtered_out(out_filtered_out)
  );

  always #5 clk = ~clk;

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fir_bandpass_21_tap_core_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Filters one new sample against the history, then shifts it in.
  function automatic sample_t filter_next(sample_t x);
    longint acc;
    longint y;
    acc = longint'(TAP_WEIGHT[0]) * longint'(x);
    for (int k = 1; k < TAP_COUNT; k++) begin
      acc += longint'(TAP_WEIGHT[k]) * longint'(past_samples[k - 1]);
    end
    // Round half up to Q4.12, then clamp to the sample range.
    y = (acc + (longint'(1) <<< (PROD_FRAC_SHIFT - 1))) >>> PROD_FRAC_SHIFT;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
    end
    if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
    end
    for (int k = TAP_COUNT - 2; k > 0; k--) begin
      past_samples[k] = past_samples[k - 1];
    end
    past_samples[0] = x;
    return sample_t'(y);
  endfunction

  // Offers one sample beat after a random gap and records what it should give.
  task automatic send_sample(input sample_t s, input bit typed, input sample_t want);
    int gap;
    sample_t predicted;
    gap = calm_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = filter_next(s);
    expected_out.push_back(typed ? want : predicted);
  endtask

  // Result side: random stall before each beat, then compare with the oldest expectation.
  always @(posedge clk) begin : result_side
    sample_t want_val;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_filtered_out));
        end else begin
          want_val = expected_out.pop_front();
          if (out_filtered_out !== want_val) begin
            report_mismatch($sformatf("filtered_out %0d, expected %0d",
                                      out_filtered_out, want_val));
          end
        end
        stall_left = calm_phase ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    block_kind_t kind;
    sample_t     s;
    int          sent;

    foreach (past_samples[k]) begin
      past_samples[k] = '0;
    end

    // Zero history after reset: zero in gives exactly zero out.
    repeat (2) begin
      row = '{sample: '0, typed: 1'b1, want: '0};
      directed_rows.push_back(row);
    end
    // Each sample takes the extreme matching its weight's sign: largest output.
    for (int j = 0; j < TAP_COUNT; j++) begin
      row.sample = (TAP_WEIGHT[j] > 0) ? SAMPLE_MAX : SAMPLE_MIN;
      row.typed  = 1'b0;
      row.want   = '0;
      directed_rows.push_back(row);
    end
    // Full-scale step between the two extremes.
    row = '{sample: SAMPLE_MIN, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
    row = '{sample: SAMPLE_MAX, typed: 1'b0, want: '0};
    directed_rows.push_back(row);

    // Synchronous reset held low at the start, then released.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part in blocks of one full window each.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind       = block_kind_t'($urandom_range(0, 9) > 5 ? $urandom_range(1, 5) : 0);
      calm_phase = ($urandom_range(0, 4) == 0);
      for (int j = 0; j < TAP_COUNT; j++) begin
        case (kind)
          BLK_EXTREME: begin
            case ($urandom_range(0, 4))
              0: s = SAMPLE_MAX;
              1: s = SAMPLE_MIN;
              2: s = '0;
              3: s = sample_t'(-1);
              default: s = sample_t'(1);
            endcase
          end
          BLK_SMALL: begin
            s = sample_t'($signed($urandom_range(0, 8192)) - 4096);
          end
          BLK_PEAK_POS: begin
            s = (TAP_WEIGHT[j] > 0) ? SAMPLE_MAX : SAMPLE_MIN;
          end
          BLK_PEAK_NEG: begin
            s = (TAP_WEIGHT[j] > 0) ? SAMPLE_MIN : SAMPLE_MAX;
          end
          BLK_IMPULSE: begin
            s = (j == 0) ? ($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN) : '0;
          end
          default: begin
            s = sample_t'($urandom);
          end
        endcase
        send_sample(s, 1'b0, '0);
        sent++;
      end
    end
    calm_phase = 1'b0;
    in_valid <= 1'b0;

    // Drain the remaining results, then allow for a stray late beat.
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("fir_bandpass_21_tap_core_tb OK");
    end else begin
      $display("fir_bandpass_21_tap_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
sv/fbp_pkg.sv
sv/fbp_cell.sv
sv/fbp_out.sv
sv/fir_bandpass_21_tap_core.sv
tb/fir_bandpass_21_tap_core_tb.sv
